### src/assert_macros.svh
// Concurrent assertion helpers, compiled out when ASSERT_OFF is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, pre, post)

`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

### src/brf_pkg.sv
package brf_pkg;

    localparam int CAPACITY  = 4096;
    localparam int MAX_BYTES = 8;

    localparam int PTR_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int BC_W   = 4;
    localparam int DATA_W = 64;
    localparam int FILL_W = 13;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_CLEAR = 2'd3
    } func_t;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             rd_last;
        logic             pop_start;
        logic [PTR_W-1:0] addr;
        logic [7:0]       wdata;
    } store_cmd_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

endpackage

### src/brf_store.sv
`include "assert_macros.svh"

module brf_store (
    input  logic                        clk,
    input  logic                        rst_n,
    input  brf_pkg::store_cmd_t         cmd,
    output logic                        pop_ack,
    output logic [brf_pkg::DATA_W-1:0]  pop_data
);

    logic [7:0]                 mem [brf_pkg::CAPACITY];
    logic [7:0]                 rdata_reg;
    logic                       rvalid_reg;
    logic                       rlast_reg;
    logic [brf_pkg::IDX_W-1:0]  idx_reg;
    logic [brf_pkg::DATA_W-1:0] acc_reg;
    logic [brf_pkg::IDX_W+2:0]  bit_pos;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    assign bit_pos = {idx_reg, 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
            rlast_reg  <= 1'b0;
            idx_reg    <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            rvalid_reg <= cmd.rd_en;
            rlast_reg  <= cmd.rd_en && cmd.rd_last;
            if (cmd.pop_start)
            begin
                idx_reg <= '0;
                acc_reg <= '0;
            end
            else if (rvalid_reg)
            begin
                acc_reg[bit_pos +: 8] <= rdata_reg;
                idx_reg <= idx_reg + brf_pkg::IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        pop_data = acc_reg;
        if (rvalid_reg)
        begin
            pop_data[bit_pos +: 8] = rdata_reg;
        end
    end

    assign pop_ack = rvalid_reg && rlast_reg;

    `ASSERT_IMPLY(a_one_port_op, clk, rst_n, cmd.wr_en, !cmd.rd_en)
    `ASSERT_IMPLY(a_no_start_in_flight, clk, rst_n, cmd.pop_start, !rvalid_reg && !cmd.rd_en)

endmodule

### src/brf_ctrl.sv
`include "assert_macros.svh"

module brf_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  func,
    input  logic [brf_pkg::BC_W-1:0]    byte_count,
    input  logic [brf_pkg::DATA_W-1:0]  push_bytes,
    input  logic                        pop_ack,
    input  logic [brf_pkg::DATA_W-1:0]  pop_data,
    output brf_pkg::store_cmd_t         cmd,
    output logic                        busy,
    output logic                        done,
    output logic                        ok,
    output logic [brf_pkg::DATA_W-1:0]  pop_bytes,
    output logic [brf_pkg::FILL_W-1:0]  fill_level
);

    localparam int SUM_W = brf_pkg::CNT_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP
    } state_t;

    state_t                      state_reg;
    logic [brf_pkg::PTR_W-1:0]   wp_reg;
    logic [brf_pkg::PTR_W-1:0]   rp_reg;
    logic [brf_pkg::CNT_W-1:0]   cnt_reg;
    logic [brf_pkg::BC_W-1:0]    left_reg;
    logic [brf_pkg::BC_W-1:0]    n_reg;
    logic [brf_pkg::DATA_W-1:0]  data_reg;
    logic                        done_reg;
    logic                        ok_reg;
    logic [brf_pkg::DATA_W-1:0]  pop_bytes_reg;

    brf_pkg::func_t              func_code;
    logic                        accept;
    logic                        n_ok;
    logic                        room;
    logic                        enough;
    logic [SUM_W-1:0]            push_sum;
    logic                        clear_accept;
    logic                        all_zero;

    assign func_code = brf_pkg::func_t'(func);
    assign accept    = start && (state_reg == ST_IDLE);
    assign n_ok      = (byte_count != '0) &&
                       (byte_count <= brf_pkg::BC_W'(brf_pkg::MAX_BYTES));
    assign push_sum  = SUM_W'(cnt_reg) + SUM_W'(byte_count);
    assign room      = push_sum <= SUM_W'(brf_pkg::CAPACITY);
    assign enough    = cnt_reg >= brf_pkg::CNT_W'(byte_count);

    assign clear_accept = accept && (func_code == brf_pkg::FUNC_CLEAR);
    assign all_zero     = (cnt_reg == '0) && (wp_reg == '0) && (rp_reg == '0);

    always_comb
    begin
        cmd.wr_en     = (state_reg == ST_PUSH);
        cmd.rd_en     = (state_reg == ST_POP) && (left_reg != '0);
        cmd.rd_last   = (left_reg == brf_pkg::BC_W'(1));
        cmd.pop_start = accept && (func_code == brf_pkg::FUNC_POP) && n_ok && enough;
        cmd.addr      = (state_reg == ST_PUSH) ? wp_reg : rp_reg;
        cmd.wdata     = data_reg[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            n_reg         <= '0;
            data_reg      <= '0;
            done_reg      <= 1'b0;
            ok_reg        <= 1'b0;
            pop_bytes_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        case (func_code)
                            brf_pkg::FUNC_PUSH:
                            begin
                                if (n_ok && room)
                                begin
                                    state_reg <= ST_PUSH;
                                    left_reg  <= byte_count;
                                    n_reg     <= byte_count;
                                    data_reg  <= push_bytes;
                                end
                                else
                                begin
                                    done_reg      <= 1'b1;
                                    ok_reg        <= 1'b0;
                                    pop_bytes_reg <= '0;
                                end
                            end
                            brf_pkg::FUNC_POP:
                            begin
                                if (n_ok && enough)
                                begin
                                    state_reg <= ST_POP;
                                    left_reg  <= byte_count;
                                    n_reg     <= byte_count;
                                end
                                else
                                begin
                                    done_reg      <= 1'b1;
                                    ok_reg        <= 1'b0;
                                    pop_bytes_reg <= '0;
                                end
                            end
                            brf_pkg::FUNC_QUERY:
                            begin
                                done_reg      <= 1'b1;
                                ok_reg        <= 1'b1;
                                pop_bytes_reg <= '0;
                            end
                            brf_pkg::FUNC_CLEAR:
                            begin
                                wp_reg        <= '0;
                                rp_reg        <= '0;
                                cnt_reg       <= '0;
                                done_reg      <= 1'b1;
                                ok_reg        <= 1'b1;
                                pop_bytes_reg <= '0;
                            end
                            default:
                            begin
                                done_reg      <= 1'b1;
                                ok_reg        <= 1'b0;
                                pop_bytes_reg <= '0;
                            end
                        endcase
                    end
                end
                ST_PUSH:
                begin
                    // write one byte per beat, lowest byte first
                    wp_reg   <= brf_pkg::next_ptr(wp_reg);
                    data_reg <= data_reg >> 8;
                    left_reg <= left_reg - brf_pkg::BC_W'(1);
                    if (left_reg == brf_pkg::BC_W'(1))
                    begin
                        cnt_reg       <= cnt_reg + brf_pkg::CNT_W'(n_reg);
                        done_reg      <= 1'b1;
                        ok_reg        <= 1'b1;
                        pop_bytes_reg <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_POP:
                begin
                    if (left_reg != '0)
                    begin
                        rp_reg   <= brf_pkg::next_ptr(rp_reg);
                        left_reg <= left_reg - brf_pkg::BC_W'(1);
                    end
                    // hold until the last read byte returns
                    if (pop_ack)
                    begin
                        cnt_reg       <= cnt_reg - brf_pkg::CNT_W'(n_reg);
                        done_reg      <= 1'b1;
                        ok_reg        <= 1'b1;
                        pop_bytes_reg <= pop_data;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign pop_bytes  = pop_bytes_reg;
    assign fill_level = brf_pkg::FILL_W'(cnt_reg);

    `ASSERT_IMPLY(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= brf_pkg::CNT_W'(brf_pkg::CAPACITY))
    `ASSERT_NEXT(a_clear_empties, clk, rst_n, clear_accept, all_zero && done_reg)
    `ASSERT_IMPLY(a_ack_after_reads, clk, rst_n, pop_ack, state_reg == ST_POP && left_reg == '0)
    `ASSERT_NEXT(a_push_moves_wp, clk, rst_n, state_reg == ST_PUSH, wp_reg != $past(wp_reg))

endmodule

### src/byte_ring_fifo_unit.sv
// Push writes its bytes in ST_PUSH, then raises done; pop raises done after the last byte
// is read back; query, clear and any failed request give done on the next cycle.
// Throughput: one request at a time; the single-port byte memory moves one byte per cycle.
// done is a one-cycle strobe that the receiver cannot stall; busy is low again while it shows.
// Reset (rst_n low, asynchronous): pointers and fill count go to zero; memory is not cleared.
module byte_ring_fifo_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  func,
    input  logic [brf_pkg::BC_W-1:0]    byte_count,
    input  logic [brf_pkg::DATA_W-1:0]  push_bytes,
    output logic                        busy,
    output logic                        done,
    output logic                        ok,
    output logic [brf_pkg::DATA_W-1:0]  pop_bytes,
    output logic [brf_pkg::FILL_W-1:0]  fill_level
);

    brf_pkg::store_cmd_t         cmd;
    logic                        pop_ack;
    logic [brf_pkg::DATA_W-1:0]  pop_data;

    brf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .func       (func),
        .byte_count (byte_count),
        .push_bytes (push_bytes),
        .pop_ack    (pop_ack),
        .pop_data   (pop_data),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done),
        .ok         (ok),
        .pop_bytes  (pop_bytes),
        .fill_level (fill_level)
    );

    brf_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .pop_ack  (pop_ack),
        .pop_data (pop_data)
    );

endmodule
